>>> rtl/tq_pkg.sv
`default_nettype none
package tq_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int SEL_MAX   = 8;

	// one table entry as it travels along the ring
	typedef struct packed {
		logic        valid;
		logic        mark;
		logic [31:0] due;
		logic [31:0] code;
		logic [3:0]  grp;
		logic [3:0]  ph;
	} slot_t;

	typedef enum logic [4:0] {
		OP_RESET      = 5'd0,
		OP_ADVANCE    = 5'd1,
		OP_SET_PHASE  = 5'd2,
		OP_ADD_PHASE  = 5'd3,
		OP_REM_PHASE  = 5'd4,
		OP_SCHEDULE   = 5'd5,
		OP_RESCHEDULE = 5'd6,
		OP_REPEAT     = 5'd7,
		OP_EXECUTE    = 5'd8,
		OP_PEEK       = 5'd9,
		OP_DELAY_EV   = 5'd10,
		OP_DELAY_ALL  = 5'd11,
		OP_DELAY_GRP  = 5'd12,
		OP_CANCEL     = 5'd13,
		OP_CANCEL_GRP = 5'd14,
		OP_TIME_OF    = 5'd15,
		OP_POP        = 5'd16
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PASS,
		ST_EVAL,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		ED_NONE,
		ED_KILL,
		ED_SETDUE,
		ED_WRITE
	} edit_t;

	// ring control from the sequencer to the cells
	typedef struct packed {
		logic  shift;
		slot_t wb;
	} ring_ctl_t;

	function automatic logic [3:0] sel_or_none(input logic [3:0] v);
		sel_or_none = (v >= 4'd1 && v <= 4'(SEL_MAX)) ? v : 4'd0;
	endfunction

endpackage
`default_nettype wire

>>> rtl/tq_in_if.sv
`default_nettype none
interface tq_in_if;
	logic        valid;
	logic        ready;
	logic [4:0]  kind;
	logic [31:0] event_code;
	logic [31:0] amount;
	logic [3:0]  group_sel;
	logic [3:0]  phase_sel;

	modport source (output valid, kind, event_code, amount, group_sel, phase_sel,
		input ready);
	modport sink (input valid, kind, event_code, amount, group_sel, phase_sel,
		output ready);
endinterface
`default_nettype wire

>>> rtl/tq_out_if.sv
`default_nettype none
interface tq_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] event_out;
	logic [31:0] due_time;
	logic [31:0] clock_now;
	logic [7:0]  active_phases;
	logic        status;

	modport source (output valid, event_out, due_time, clock_now, active_phases, status,
		input ready);
	modport sink (input valid, event_out, due_time, clock_now, active_phases, status,
		output ready);
endinterface
`default_nettype wire

>>> rtl/tq_cell.sv
`default_nettype none
module tq_cell (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          shift,
	input  wire tq_pkg::slot_t d,
	output tq_pkg::slot_t      q
);
	import tq_pkg::*;

	logic  valid_q;
	logic  mark_q;
	slot_t pay_q;

	// valid and mark bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mark_q  <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
			mark_q  <= d.mark;
		end
	end

	// entry contents
	always_ff @(posedge clk) begin
		if (shift) begin
			pay_q <= d;
		end
	end

	always_comb begin
		q       = pay_q;
		q.valid = valid_q;
		q.mark  = mark_q;
	end
endmodule
`default_nettype wire

>>> rtl/tq_ctrl.sv
`default_nettype none
module tq_ctrl #(
	parameter int SLOTS = tq_pkg::SLOTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	tq_in_if.sink              in_ch,
	tq_out_if.source           out_ch,
	input  wire tq_pkg::slot_t tail,
	output tq_pkg::ring_ctl_t  ring
);
	import tq_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KW = $clog2(SLOTS + 1);

	state_t        state_q, state_d;
	logic          stg_q, stg_d;
	logic          first_q, first_d;
	logic [IW-1:0] step_q, step_d;
	logic [KW-1:0] k_q, k_d;
	logic [4:0]    op_q;
	logic [31:0]   code_q, amt_q;
	logic [3:0]    g_q, ph_q;
	logic [31:0]   clock_q, clock_d;
	logic [7:0]    pmask_q, pmask_d;
	logic [31:0]   base_q, base_d, limit_q;
	edit_t         edit_q, edit_d;
	logic [IW-1:0] eidx_q, eidx_d;
	logic [31:0]   edue_q, edue_d;
	logic [31:0]   ev_q, ev_d, due_q, due_d;
	logic          st_q, st_d;

	// pass accumulators
	logic          mf_q, mf_c;
	logic [IW-1:0] mi_q, mi_c;
	logic [31:0]   md_q, md_c, me_q, me_c;
	logic [3:0]    mp_q, mp_c;
	logic          ff_q, ff_c;
	logic [IW-1:0] fi_q, fi_c;
	logic [SLOTS:0] tm_q, tm_c, tm_d;

	logic          out_valid_q;
	logic [31:0]   out_ev_q, out_due_q, out_clk_q;
	logic [7:0]    out_pm_q;
	logic          out_st_q;

	logic          in_acc, leave_done;
	slot_t         e;
	logic          cand;
	logic [31:0]   dd, dmin;
	logic [2:0]    pidx;
	logic          blocked;
	logic [3:0]    gsel_in;

	assign in_acc     = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign leave_done = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);
	assign gsel_in    = sel_or_none(in_ch.group_sel);

	// entry leaving the tail of the ring, with this pass's edits applied
	always_comb begin
		e = tail;
		if (first_q) begin
			if (op_q == OP_RESET) e.valid = 1'b0;
			if ((op_q == OP_CANCEL || op_q == OP_RESCHEDULE) && e.code == code_q)
				e.valid = 1'b0;
			if (op_q == OP_CANCEL_GRP && e.grp == g_q) e.valid = 1'b0;
			if (op_q == OP_DELAY_EV || op_q == OP_DELAY_GRP) e.mark = 1'b0;
		end
		if (step_q == eidx_q) begin
			case (edit_q)
				ED_KILL: e.valid = 1'b0;
				ED_SETDUE: begin
					e.due  = edue_q;
					e.mark = 1'b1;
				end
				ED_WRITE: begin
					e.valid = 1'b1;
					e.mark  = 1'b0;
					e.due   = edue_q;
					e.code  = code_q;
					e.grp   = g_q;
					e.ph    = ph_q;
				end
				default: ;
			endcase
		end
		ring.wb    = e;
		ring.shift = (state_q == ST_PASS);
	end

	// per-op filter for the minimum search
	always_comb begin
		case (op_q)
			OP_TIME_OF: cand = e.valid && e.code == code_q;
			OP_DELAY_EV: cand = e.valid && !e.mark && e.due < limit_q && e.code == code_q;
			OP_DELAY_GRP: cand = e.valid && !e.mark && e.due < limit_q && e.grp == g_q;
			default: cand = e.valid;
		endcase
	end

	// accumulate minimum, free slot and taken-time window over one pass
	always_comb begin
		mf_c = (step_q == '0) ? 1'b0 : mf_q;
		mi_c = mi_q;
		md_c = md_q;
		me_c = me_q;
		mp_c = mp_q;
		ff_c = (step_q == '0) ? 1'b0 : ff_q;
		fi_c = fi_q;
		tm_c = (step_q == '0) ? '0 : tm_q;
		dd   = e.due - base_q;
		if (cand && (!mf_c || e.due < md_c)) begin
			mf_c = 1'b1;
			mi_c = step_q;
			md_c = e.due;
			me_c = e.code;
			mp_c = e.ph;
		end
		if (!e.valid && !ff_c) begin
			ff_c = 1'b1;
			fi_c = step_q;
		end
		if (e.valid && dd <= 32'(SLOTS)) tm_c[dd[KW-1:0]] = 1'b1;
	end

	assign dmin    = md_q - base_q;
	assign pidx    = mp_q[2:0] - 3'd1;
	assign blocked = (pmask_q != 8'd0) && (mp_q != 4'd0) && !pmask_q[pidx];

	// state, clock and phase mask registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clock_q <= '0;
			pmask_q <= '0;
		end else begin
			state_q <= state_d;
			clock_q <= clock_d;
			pmask_q <= pmask_d;
		end
	end

	// next state and sequencing
	always_comb begin
		state_d = state_q;
		stg_d   = stg_q;
		first_d = first_q;
		step_d  = step_q;
		k_d     = k_q;
		clock_d = clock_q;
		pmask_d = pmask_q;
		base_d  = base_q;
		edit_d  = edit_q;
		eidx_d  = eidx_q;
		edue_d  = edue_q;
		ev_d    = ev_q;
		due_d   = due_q;
		st_d    = st_q;
		tm_d    = tm_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					ev_d    = '0;
					due_d   = '0;
					st_d    = 1'b0;
					stg_d   = 1'b0;
					first_d = 1'b1;
					edit_d  = ED_NONE;
					step_d  = '0;
					base_d  = clock_q + in_ch.amount;
					state_d = ST_PASS;
					case (in_ch.kind)
						OP_RESET: begin
							clock_d = '0;
							pmask_d = '0;
						end
						OP_ADVANCE: begin
							clock_d = clock_q + in_ch.amount;
							state_d = ST_DONE;
						end
						OP_SET_PHASE: begin
							if (in_ch.phase_sel == 4'd0) pmask_d = '0;
							else if (in_ch.phase_sel <= 4'(SEL_MAX))
								pmask_d = 8'd1 << (in_ch.phase_sel[2:0] - 3'd1);
							state_d = ST_DONE;
						end
						OP_ADD_PHASE: begin
							if (sel_or_none(in_ch.phase_sel) != 4'd0)
								pmask_d = pmask_q | (8'd1 << (in_ch.phase_sel[2:0] - 3'd1));
							state_d = ST_DONE;
						end
						OP_REM_PHASE: begin
							if (sel_or_none(in_ch.phase_sel) != 4'd0)
								pmask_d = pmask_q & ~(8'd1 << (in_ch.phase_sel[2:0] - 3'd1));
							state_d = ST_DONE;
						end
						OP_DELAY_ALL: begin
							clock_d = (in_ch.amount < clock_q) ? clock_q - in_ch.amount : '0;
							state_d = ST_DONE;
						end
						OP_DELAY_GRP, OP_CANCEL_GRP: begin
							if (gsel_in == 4'd0) state_d = ST_DONE;
						end
						OP_SCHEDULE, OP_RESCHEDULE, OP_REPEAT, OP_EXECUTE, OP_PEEK,
						OP_DELAY_EV, OP_CANCEL, OP_TIME_OF, OP_POP: ;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_PASS: begin
				step_d = step_q + 1'b1;
				tm_d   = tm_c;
				if (step_q == IW'(SLOTS - 1)) begin
					step_d  = '0;
					first_d = 1'b0;
					edit_d  = ED_NONE;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ST_DONE;
				k_d     = '0;
				case (op_q)
					OP_TIME_OF: due_d = mf_q ? md_q : '0;
					OP_SCHEDULE, OP_RESCHEDULE: begin
						if (!stg_q) begin
							if (!ff_q) st_d = 1'b1;
							else state_d = ST_SCAN;
						end
					end
					OP_REPEAT: begin
						if (!stg_q && mf_q) begin
							if (dmin <= 32'(SLOTS)) tm_d[dmin[KW-1:0]] = 1'b0;
							state_d = ST_SCAN;
						end
					end
					OP_EXECUTE, OP_PEEK: begin
						if (!stg_q && mf_q && md_q <= clock_q) begin
							if (blocked) begin
								edit_d  = ED_KILL;
								eidx_d  = mi_q;
								state_d = ST_PASS;
							end else begin
								ev_d = me_q;
								if (op_q == OP_EXECUTE) begin
									edit_d  = ED_KILL;
									eidx_d  = mi_q;
									stg_d   = 1'b1;
									state_d = ST_PASS;
								end
							end
						end
					end
					OP_POP: begin
						if (!stg_q && mf_q) begin
							edit_d  = ED_KILL;
							eidx_d  = mi_q;
							stg_d   = 1'b1;
							state_d = ST_PASS;
						end
					end
					OP_DELAY_EV, OP_DELAY_GRP: begin
						if (stg_q) state_d = ST_SCAN;
						else if (mf_q) begin
							base_d  = md_q + amt_q;
							stg_d   = 1'b1;
							state_d = ST_PASS;
						end
					end
					default: ;
				endcase
			end
			ST_SCAN: begin
				if (!tm_q[k_q]) begin
					edue_d  = base_q + 32'(k_q);
					state_d = ST_PASS;
					if (op_q == OP_SCHEDULE || op_q == OP_RESCHEDULE) begin
						edit_d = ED_WRITE;
						eidx_d = fi_q;
						stg_d  = 1'b1;
					end else begin
						edit_d = ED_SETDUE;
						eidx_d = mi_q;
						stg_d  = (op_q == OP_REPEAT);
					end
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (leave_done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		stg_q   <= stg_d;
		first_q <= first_d;
		step_q  <= step_d;
		k_q     <= k_d;
		base_q  <= base_d;
		edit_q  <= edit_d;
		eidx_q  <= eidx_d;
		edue_q  <= edue_d;
		ev_q    <= ev_d;
		due_q   <= due_d;
		st_q    <= st_d;
		tm_q    <= tm_d;
		if (in_acc) begin
			op_q    <= in_ch.kind;
			code_q  <= in_ch.event_code;
			amt_q   <= in_ch.amount;
			g_q     <= gsel_in;
			ph_q    <= sel_or_none(in_ch.phase_sel);
			limit_q <= clock_q + in_ch.amount;
		end
		if (state_q == ST_PASS) begin
			mf_q <= mf_c;
			mi_q <= mi_c;
			md_q <= md_c;
			me_q <= me_c;
			mp_q <= mp_c;
			ff_q <= ff_c;
			fi_q <= fi_c;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (leave_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (leave_done) begin
			out_ev_q  <= ev_q;
			out_due_q <= due_q;
			out_clk_q <= clock_q;
			out_pm_q  <= pmask_q;
			out_st_q  <= st_q;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.event_out     = out_ev_q;
	assign out_ch.due_time      = out_due_q;
	assign out_ch.clock_now     = out_clk_q;
	assign out_ch.active_phases = out_pm_q;
	assign out_ch.status        = out_st_q;
endmodule
`default_nettype wire

>>> rtl/timed_event_queue_unit.sv
// channel | dir | beat contents
// in_ch   | in  | kind, event_code, amount, group_sel, phase_sel
// out_ch  | out | event_out, due_time, clock_now, active_phases, status
//
// clock, phase and unused kinds go from accept straight to the done state and result register.
// table kinds rotate the ring of SLOTS cells once per pass, then evaluate.
// schedule and repeat take two passes plus a free-time scan over up to SLOTS+1 due times;
// execute takes one pass per dropped event; each delayed entry costs two passes and a scan.
// reset clears clock and mask at once and the entry valid bits in one clearing pass.
// a new beat is taken while the last result still waits on a stalled output.
`default_nettype none
module timed_event_queue_unit #(
	parameter int SLOTS = tq_pkg::SLOTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	tq_in_if.sink    in_ch,
	tq_out_if.source out_ch
);
	import tq_pkg::*;

	slot_t     link [SLOTS];
	ring_ctl_t ring;

	tq_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.tail   (link[SLOTS-1]),
		.ring   (ring)
	);

	// ring of entry cells, head fed by the sequencer's write-back
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		tq_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (ring.shift),
			.d      ((i == 0) ? ring.wb : link[(i == 0) ? 0 : i - 1]),
			.q      (link[i])
		);
	end
endmodule
`default_nettype wire

>>> rtl/tq_checker.sv
`default_nettype none
module tq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] event_out,
	input wire logic [31:0] due_time,
	input wire logic        status
);
	// one command at a time: no back-to-back accepts
	a_no_b2b: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !(in_valid && in_ready))
		else $error("input accepted on consecutive cycles");

	// event and time results come from different kinds
	a_ev_due: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_out == 32'd0 || due_time == 32'd0))
		else $error("event and due time both set");

	// a full-table result carries nothing else
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (event_out == 32'd0 && due_time == 32'd0))
		else $error("full status with payload");

	// result holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");
endmodule

bind timed_event_queue_unit tq_checker u_tq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.event_out (out_ch.event_out),
	.due_time  (out_ch.due_time),
	.status    (out_ch.status)
);
`default_nettype wire

>>> dv/tb_top.sv
module tb_top;
	import tq_pkg::*;

	localparam int NSLOT      = 16;
	localparam int N_RANDOM   = 850;
	localparam int WDOG_LIMIT = 40000;
	localparam int LONG_HOLD  = 400;

	typedef struct {
		logic [31:0] ev;
		logic [31:0] due;
		logic [31:0] clk_now;
		logic [7:0]  mask;
		logic        st;
	} result_t;

	typedef struct {
		logic [4:0]  kind;
		logic [31:0] code;
		logic [31:0] amt;
		logic [3:0]  grp;
		logic [3:0]  ph;
		bit          typed;
		result_t     res;
	} cmd_t;

	logic clk;
	logic arst_n;

	tq_in_if  in_ch();
	tq_out_if out_ch();

	timed_event_queue_unit #(.SLOTS(NSLOT)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// mirror of the event table
	bit          tbl_valid [NSLOT];
	logic [31:0] tbl_due   [NSLOT];
	logic [31:0] tbl_code  [NSLOT];
	logic [3:0]  tbl_grp   [NSLOT];
	logic [3:0]  tbl_ph    [NSLOT];
	logic [31:0] tq_clock;
	logic [7:0]  tq_mask;

	result_t pending_results[$];
	cmd_t    directed[$];
	int      errors;
	int      results_seen;
	bit      stim_done;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic logic [3:0] valid_sel(logic [3:0] v);
		return (v >= 4'd1 && v <= 4'd8) ? v : 4'd0;
	endfunction

	function automatic int earliest_entry();
		int best;
		best = -1;
		for (int i = 0; i < NSLOT; i++)
			if (tbl_valid[i] && (best < 0 || tbl_due[i] < tbl_due[best]))
				best = i;
		return best;
	endfunction

	function automatic bit due_taken(logic [31:0] t);
		for (int i = 0; i < NSLOT; i++)
			if (tbl_valid[i] && tbl_due[i] == t)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic logic [31:0] free_due_from(logic [31:0] t);
		for (int k = 0; k <= NSLOT; k++) begin
			if (!due_taken(t))
				return t;
			t = t + 32'd1;
		end
		return t;
	endfunction

	function automatic bit add_event(logic [31:0] code, logic [31:0] amt, logic [3:0] g,
		logic [3:0] p);
		int s;
		s = -1;
		for (int i = 0; i < NSLOT; i++)
			if (!tbl_valid[i] && s < 0)
				s = i;
		if (s < 0)
			return 1'b0;
		tbl_due[s]   = free_due_from(tq_clock + amt);
		tbl_code[s]  = code;
		tbl_grp[s]   = valid_sel(g);
		tbl_ph[s]    = valid_sel(p);
		tbl_valid[s] = 1'b1;
		return 1'b1;
	endfunction

	function automatic void drop_code(logic [31:0] code);
		for (int i = 0; i < NSLOT; i++)
			if (tbl_valid[i] && tbl_code[i] == code)
				tbl_valid[i] = 1'b0;
	endfunction

	// earliest due event, dropping ones whose phase is masked off
	function automatic logic [31:0] take_due(bit take);
		int s;
		forever begin
			s = earliest_entry();
			if (s < 0 || tbl_due[s] > tq_clock)
				return 32'd0;
			if (tq_mask != 8'd0 && tbl_ph[s] != 4'd0 &&
				tq_mask[tbl_ph[s] - 4'd1] == 1'b0) begin
				tbl_valid[s] = 1'b0;
			end else begin
				if (take)
					tbl_valid[s] = 1'b0;
				return tbl_code[s];
			end
		end
	endfunction

	// push matching entries below clock+amt later by amt, each once
	function automatic void push_later(logic [31:0] amt, bit by_group, logic [31:0] key);
		bit          moved [NSLOT];
		logic [31:0] lim;
		int          best;
		bit          hit;
		lim = tq_clock + amt;
		for (int i = 0; i < NSLOT; i++)
			moved[i] = 1'b0;
		forever begin
			best = -1;
			for (int i = 0; i < NSLOT; i++) begin
				if (tbl_valid[i] && !moved[i] && tbl_due[i] < lim) begin
					hit = by_group ? (32'(tbl_grp[i]) == key) : (tbl_code[i] == key);
					if (hit && (best < 0 || tbl_due[i] < tbl_due[best]))
						best = i;
				end
			end
			if (best < 0)
				return;
			tbl_due[best] = free_due_from(tbl_due[best] + amt);
			moved[best]   = 1'b1;
		end
	endfunction

	function automatic void clear_table();
		for (int i = 0; i < NSLOT; i++)
			tbl_valid[i] = 1'b0;
		tq_clock = 32'd0;
		tq_mask  = 8'd0;
	endfunction

	// apply one command to the mirror and return its result beat
	function automatic result_t apply_cmd(cmd_t c);
		result_t    r;
		logic [3:0] g;
		int         s;
		r = '{ev: 32'd0, due: 32'd0, clk_now: 32'd0, mask: 8'd0, st: 1'b0};
		g = valid_sel(c.grp);
		case (c.kind)
			OP_RESET: clear_table();
			OP_ADVANCE: tq_clock = tq_clock + c.amt;
			OP_SET_PHASE: begin
				if (c.ph == 4'd0)
					tq_mask = 8'd0;
				else if (c.ph <= 4'd8)
					tq_mask = 8'd1 << (c.ph - 4'd1);
			end
			OP_ADD_PHASE: begin
				if (c.ph >= 4'd1 && c.ph <= 4'd8)
					tq_mask = tq_mask | (8'd1 << (c.ph - 4'd1));
			end
			OP_REM_PHASE: begin
				if (c.ph >= 4'd1 && c.ph <= 4'd8)
					tq_mask = tq_mask & ~(8'd1 << (c.ph - 4'd1));
			end
			OP_SCHEDULE: r.st = !add_event(c.code, c.amt, c.grp, c.ph);
			OP_RESCHEDULE: begin
				drop_code(c.code);
				r.st = !add_event(c.code, c.amt, c.grp, c.ph);
			end
			OP_REPEAT: begin
				s = earliest_entry();
				if (s >= 0) begin
					tbl_valid[s] = 1'b0;
					tbl_due[s]   = free_due_from(tq_clock + c.amt);
					tbl_valid[s] = 1'b1;
				end
			end
			OP_EXECUTE: r.ev = take_due(1'b1);
			OP_PEEK: r.ev = take_due(1'b0);
			OP_DELAY_EV: push_later(c.amt, 1'b0, c.code);
			OP_DELAY_ALL: tq_clock = (c.amt < tq_clock) ? tq_clock - c.amt : 32'd0;
			OP_DELAY_GRP: begin
				if (g != 4'd0)
					push_later(c.amt, 1'b1, 32'(g));
			end
			OP_CANCEL: drop_code(c.code);
			OP_CANCEL_GRP: begin
				if (g != 4'd0)
					for (int i = 0; i < NSLOT; i++)
						if (tbl_valid[i] && tbl_grp[i] == g)
							tbl_valid[i] = 1'b0;
			end
			OP_TIME_OF: begin
				s = -1;
				for (int i = 0; i < NSLOT; i++)
					if (tbl_valid[i] && tbl_code[i] == c.code &&
						(s < 0 || tbl_due[i] < tbl_due[s]))
						s = i;
				if (s >= 0)
					r.due = tbl_due[s];
			end
			OP_POP: begin
				s = earliest_entry();
				if (s >= 0)
					tbl_valid[s] = 1'b0;
			end
			default: ;
		endcase
		r.clk_now = tq_clock;
		r.mask    = tq_mask;
		return r;
	endfunction

	task automatic add_row(op_t k, logic [31:0] code, logic [31:0] amt, logic [3:0] g,
		logic [3:0] p, bit typed = 1'b0, logic [31:0] ev = 0, logic [31:0] due = 0,
		logic [31:0] clk_now = 0, logic [7:0] mask = 0, logic st = 0);
		cmd_t c;
		c.kind  = k;
		c.code  = code;
		c.amt   = amt;
		c.grp   = g;
		c.ph    = p;
		c.typed = typed;
		c.res   = '{ev: ev, due: due, clk_now: clk_now, mask: mask, st: st};
		directed.push_back(c);
	endtask

	function automatic logic [31:0] rand_code();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFFFFFF;
			default: return 32'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic logic [31:0] rand_amount();
		case ($urandom_range(0, 11))
			0: return $urandom();
			1: return 32'hFFFFFFFF - 32'($urandom_range(0, 20));
			default: return 32'($urandom_range(0, 24));
		endcase
	endfunction

	// weighted toward schedules and executes so the table stays busy
	function automatic cmd_t rand_cmd();
		cmd_t c;
		int   w;
		w = $urandom_range(0, 99);
		if (w < 1)       c.kind = OP_RESET;
		else if (w < 10) c.kind = OP_ADVANCE;
		else if (w < 15) c.kind = 5'($urandom_range(2, 4));
		else if (w < 40) c.kind = OP_SCHEDULE;
		else if (w < 46) c.kind = OP_RESCHEDULE;
		else if (w < 49) c.kind = OP_REPEAT;
		else if (w < 63) c.kind = OP_EXECUTE;
		else if (w < 67) c.kind = OP_PEEK;
		else if (w < 71) c.kind = OP_DELAY_EV;
		else if (w < 73) c.kind = OP_DELAY_ALL;
		else if (w < 77) c.kind = OP_DELAY_GRP;
		else if (w < 81) c.kind = OP_CANCEL;
		else if (w < 84) c.kind = OP_CANCEL_GRP;
		else if (w < 90) c.kind = OP_TIME_OF;
		else if (w < 96) c.kind = OP_POP;
		else             c.kind = 5'($urandom_range(17, 31));
		c.code  = rand_code();
		c.amt   = rand_amount();
		c.grp   = 4'($urandom_range(0, 15));
		c.ph    = 4'($urandom_range(0, 15));
		c.typed = 1'b0;
		return c;
	endfunction

	task automatic report(string field, logic [31:0] got, logic [31:0] want);
		$display("mismatch on result %0d: %s got %h want %h", results_seen, field, got, want);
		errors++;
	endtask

	// offer one beat and record its expectation on acceptance
	task automatic send_cmd(cmd_t c, int gap);
		result_t r;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.kind       <= c.kind;
		in_ch.event_code <= c.code;
		in_ch.amount     <= c.amt;
		in_ch.group_sel  <= c.grp;
		in_ch.phase_sel  <= c.ph;
		do
			@(posedge clk);
		while (!in_ch.ready);
		r = apply_cmd(c);
		pending_results.push_back(c.typed ? c.res : r);
	endtask

	// sender
	initial begin
		int gap;
		in_ch.valid      = 1'b0;
		in_ch.kind       = '0;
		in_ch.event_code = '0;
		in_ch.amount     = '0;
		in_ch.group_sel  = '0;
		in_ch.phase_sel  = '0;
		errors           = 0;
		results_seen     = 0;
		stim_done        = 1'b0;
		clear_table();
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(OP_RESET, 0, 0, 0, 0, 1, 0, 0, 32'd0, 8'h00, 0);
		add_row(OP_ADVANCE, 0, 32'hFFFFFFFF, 0, 0, 1, 0, 0, 32'hFFFFFFFF, 8'h00, 0);
		add_row(OP_ADVANCE, 0, 32'd1, 0, 0, 1, 0, 0, 32'd0, 8'h00, 0);
		add_row(OP_SET_PHASE, 0, 0, 0, 4'd8, 1, 0, 0, 32'd0, 8'h80, 0);
		add_row(OP_SET_PHASE, 0, 0, 0, 4'd15, 1, 0, 0, 32'd0, 8'h80, 0);
		add_row(OP_ADD_PHASE, 0, 0, 0, 4'd1, 1, 0, 0, 32'd0, 8'h81, 0);
		add_row(OP_ADD_PHASE, 0, 0, 0, 4'd0, 1, 0, 0, 32'd0, 8'h81, 0);
		add_row(OP_REM_PHASE, 0, 0, 0, 4'd8, 1, 0, 0, 32'd0, 8'h01, 0);
		add_row(OP_REM_PHASE, 0, 0, 0, 4'd12, 1, 0, 0, 32'd0, 8'h01, 0);
		add_row(OP_SET_PHASE, 0, 0, 0, 4'd0, 1, 0, 0, 32'd0, 8'h00, 0);
		add_row(OP_SCHEDULE, 32'd5, 32'd3, 4'd9, 4'd0, 1, 0, 0, 32'd0, 8'h00, 0);
		// same due time moves one tick on
		add_row(OP_SCHEDULE, 32'hFFFFFFFF, 32'd3, 4'd2, 4'd3);
		add_row(OP_TIME_OF, 32'hFFFFFFFF, 0, 0, 0);
		add_row(OP_PEEK, 0, 0, 0, 0);
		add_row(OP_REPEAT, 0, 32'd4, 0, 0);
		add_row(OP_DELAY_EV, 32'hFFFFFFFF, 32'd10, 0, 0);
		add_row(OP_DELAY_GRP, 0, 32'd10, 4'd2, 0);
		add_row(OP_DELAY_GRP, 0, 32'd10, 4'd0, 0);
		add_row(OP_CANCEL_GRP, 0, 0, 4'd2, 0);
		add_row(OP_CANCEL, 32'd5, 0, 0, 0);
		add_row(OP_POP, 0, 0, 0, 0);
		add_row(OP_EXECUTE, 0, 0, 0, 0, 1, 32'd0, 0, 32'd0, 8'h00, 0);
		add_row(OP_ADVANCE, 0, 32'd100, 0, 0);
		add_row(OP_DELAY_ALL, 0, 32'hFFFFFFFF, 0, 0, 1, 0, 0, 32'd0, 8'h00, 0);
		add_row(op_t'(5'd31), 0, 0, 0, 0, 1, 0, 0, 32'd0, 8'h00, 0);
		// masked phase is dropped on execute
		add_row(OP_SCHEDULE, 32'd7, 32'd2, 0, 4'd3);
		add_row(OP_SCHEDULE, 32'd8, 32'd5, 0, 4'd1);
		add_row(OP_SET_PHASE, 0, 0, 0, 4'd1);
		add_row(OP_ADVANCE, 0, 32'd50, 0, 0);
		add_row(OP_EXECUTE, 0, 0, 0, 0);
		add_row(OP_EXECUTE, 0, 0, 0, 0);

		foreach (directed[i])
			send_cmd(directed[i], $urandom_range(0, 3));

		for (int n = 0; n < N_RANDOM; n++) begin
			// drain completely once, then a burst with no gaps
			if (n == 400) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			gap = (n >= 600 && n < 680) ? 0 : $urandom_range(0, 17);
			send_cmd(rand_cmd(), gap);
		end
		in_ch.valid <= 1'b0;
		stim_done   <= 1'b1;
	end

	// receiver and checker
	initial begin
		int      stall;
		result_t want;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_seen == 120)
				stall = LONG_HOLD;
			else if (results_seen >= 600 && results_seen < 680)
				stall = 0;
			else
				stall = $urandom_range(0, 17);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_ch.valid);
			if (pending_results.size() == 0) begin
				$display("unexpected result beat %0d", results_seen);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.event_out !== want.ev)
					report("event_out", out_ch.event_out, want.ev);
				if (out_ch.due_time !== want.due)
					report("due_time", out_ch.due_time, want.due);
				if (out_ch.clock_now !== want.clk_now)
					report("clock_now", out_ch.clock_now, want.clk_now);
				if (out_ch.active_phases !== want.mask)
					report("active_phases", 32'(out_ch.active_phases), 32'(want.mask));
				if (out_ch.status !== want.st)
					report("status", 32'(out_ch.status), 32'(want.st));
			end
			results_seen++;
		end
	end

	// watchdog on cycles without any accepted beat
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle = 0;
			else
				idle++;
			if (idle >= WDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// end of run
	initial begin
		@(posedge clk);
		while (!stim_done || pending_results.size() != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
